[rtl/isqrt_pkg.sv]
// Shared definitions for the integer square root block: widths, the seed
// table, the control word layout and the microcode program.
// No dependencies; used by isqrt_div and integer_square_root.
package isqrt_pkg;

    localparam int RAD_W  = 32;
    localparam int ROOT_W = 16;
    localparam int STEP_W = 3;
    localparam int CNT_W  = $clog2(RAD_W + 1);

    localparam logic [RAD_W-1:0] ROOT_MAX = RAD_W'((1 << ROOT_W) - 1);

    typedef logic [STEP_W-1:0] step_t;

    // Microcode addresses. The program counter wraps from the last step back
    // to STEP_IDLE.
    localparam step_t STEP_IDLE  = 3'd0;
    localparam step_t STEP_ZCHK  = 3'd1;
    localparam step_t STEP_START = 3'd2;
    localparam step_t STEP_WAIT  = 3'd3;
    localparam step_t STEP_AVG   = 3'd4;
    localparam step_t STEP_CMP   = 3'd5;
    localparam step_t STEP_UPD   = 3'd6;
    localparam step_t STEP_OUT   = 3'd7;

    // Jump conditions; when the condition holds the sequencer jumps to the
    // target, otherwise it falls through to the next step.
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_CUR_ZERO,
        COND_DIV_BUSY,
        COND_CONVERGED,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        logic  take_in;
        logic  div_start;
        logic  ld_next;
        logic  upd_est;
        logic  give_out;
        cond_t cond;
        step_t target;
    } ctrl_t;

    function automatic ctrl_t rom_word(input step_t pc);
        ctrl_t cw;
        cw = '{take_in: 1'b0, div_start: 1'b0, ld_next: 1'b0, upd_est: 1'b0,
               give_out: 1'b0, cond: COND_NEVER, target: STEP_IDLE};
        unique case (pc)
            STEP_IDLE: begin
                cw.take_in = 1'b1;
                cw.cond    = COND_NO_INPUT;
                cw.target  = STEP_IDLE;
            end
            STEP_ZCHK: begin
                cw.cond   = COND_CUR_ZERO;
                cw.target = STEP_OUT;
            end
            STEP_START: begin
                cw.div_start = 1'b1;
            end
            STEP_WAIT: begin
                cw.cond   = COND_DIV_BUSY;
                cw.target = STEP_WAIT;
            end
            STEP_AVG: begin
                cw.ld_next = 1'b1;
            end
            STEP_CMP: begin
                cw.cond   = COND_CONVERGED;
                cw.target = STEP_OUT;
            end
            STEP_UPD: begin
                cw.upd_est = 1'b1;
                cw.cond    = COND_ALWAYS;
                cw.target  = STEP_ZCHK;
            end
            STEP_OUT: begin
                cw.give_out = 1'b1;
                cw.cond     = COND_OUT_BUSY;
                cw.target   = STEP_OUT;
            end
            default: begin
                cw.cond   = COND_ALWAYS;
                cw.target = STEP_IDLE;
            end
        endcase
        return cw;
    endfunction

    // First estimate from the decimal digit count of the radicand.
    function automatic logic [RAD_W-1:0] seed_for(input logic [RAD_W-1:0] v);
        logic [RAD_W-1:0] s;
        if (v < 32'd10)              s = 32'd2;
        else if (v < 32'd100)        s = 32'd6;
        else if (v < 32'd1000)       s = 32'd20;
        else if (v < 32'd10000)      s = 32'd60;
        else if (v < 32'd100000)     s = 32'd200;
        else if (v < 32'd1000000)    s = 32'd600;
        else if (v < 32'd10000000)   s = 32'd2000;
        else if (v < 32'd100000000)  s = 32'd6000;
        else if (v < 32'd1000000000) s = 32'd20000;
        else                         s = 32'd60000;
        return s;
    endfunction

endpackage

[rtl/isqrt_div.sv]
// Restoring divider for the integer square root block: one quotient bit
// per cycle. Depends on isqrt_pkg.
module isqrt_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [isqrt_pkg::RAD_W-1:0]   dividend,
    input  logic [isqrt_pkg::RAD_W-1:0]   divisor,
    output logic                          busy,
    output logic [isqrt_pkg::RAD_W-1:0]   quotient
);

    localparam int W = isqrt_pkg::RAD_W;

    logic [W-1:0]                  rem_reg, rem_next;
    logic [W-1:0]                  quo_reg, quo_next;
    logic [W-1:0]                  dsr_reg, dsr_next;
    logic [isqrt_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic [W:0]                    shifted;
    logic [W:0]                    diff;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = isqrt_pkg::CNT_W'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // The partial remainder stays below the divisor, so it fits W bits.
            if (!diff[W]) begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - isqrt_pkg::CNT_W'(1);
            busy_next = (cnt_reg != isqrt_pkg::CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

[rtl/integer_square_root.sv]
// Integer square root by Newton iteration under microcode control.
// Depends on isqrt_pkg and isqrt_div.
//
// Usage: the input channel (s_valid, s_ready, s_radicand) takes one 32-bit
// unsigned radicand per transaction; the result channel (m_valid, m_ready,
// m_root) returns one 16-bit root per radicand, in order. The root is the
// floor of the square root, or one above it when the radicand is one less
// than a perfect square, saturated at 65535.
// Timing: one radicand at a time. Each Newton step starts a division on
// the single bit-serial divider (one quotient bit per cycle), waits for
// it, then averages, compares and updates the estimate; the last step
// trades its update for the output step. m_valid and s_ready rise
// together, when the result is loaded and the sequencer is back in idle.
// A radicand of zero runs two divisions to a zero estimate, then the zero
// check and output.
// The result sits in an output register; the block returns to accepting
// a new radicand as soon as the result is loaded there, and if the
// receiver is still holding off the previous result the sequencer waits
// in its output step until the register frees up. Reset (aresetn low at a
// clock edge) returns the sequencer to idle and drops m_valid.
module integer_square_root (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [isqrt_pkg::RAD_W-1:0]    s_radicand,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [isqrt_pkg::ROOT_W-1:0]   m_root
);

    localparam int W = isqrt_pkg::RAD_W;

    isqrt_pkg::step_t              pc_reg, pc_next;
    isqrt_pkg::ctrl_t              cw;
    logic                          jump;

    logic [W-1:0]                  rad_reg;
    logic [W-1:0]                  cur_reg, cur_next;
    logic [W-1:0]                  prev_reg, prev_next;
    logic [W-1:0]                  next_reg;
    logic [W:0]                    sum;
    logic [W-1:0]                  seed;

    logic                          div_busy;
    logic [W-1:0]                  quotient;

    logic                          out_valid_reg, out_valid_next;
    logic [isqrt_pkg::ROOT_W-1:0]  out_root_reg;
    logic                          out_busy;
    logic                          converged;
    logic                          accept;

    assign cw        = isqrt_pkg::rom_word(pc_reg);
    assign accept    = cw.take_in && s_valid;
    assign out_busy  = out_valid_reg && !m_ready;
    assign converged = (next_reg == cur_reg) || (next_reg == prev_reg);
    assign seed      = isqrt_pkg::seed_for(s_radicand);
    assign sum       = {1'b0, cur_reg} + {1'b0, quotient};

    isqrt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cw.div_start),
        .dividend (rad_reg),
        .divisor  (cur_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // Condition select for the sequencer.
    always_comb begin
        unique case (cw.cond)
            isqrt_pkg::COND_NEVER:     jump = 1'b0;
            isqrt_pkg::COND_ALWAYS:    jump = 1'b1;
            isqrt_pkg::COND_NO_INPUT:  jump = !s_valid;
            isqrt_pkg::COND_CUR_ZERO:  jump = (cur_reg == '0);
            isqrt_pkg::COND_DIV_BUSY:  jump = div_busy;
            isqrt_pkg::COND_CONVERGED: jump = converged;
            isqrt_pkg::COND_OUT_BUSY:  jump = out_busy;
            default:                   jump = 1'b0;
        endcase
        pc_next = jump ? cw.target : pc_reg + isqrt_pkg::STEP_W'(1);
    end

    always_comb begin
        cur_next  = cur_reg;
        prev_next = prev_reg;
        if (accept) begin
            cur_next  = seed;
            prev_next = seed;
        end else if (cw.upd_est) begin
            prev_next = cur_reg;
            cur_next  = next_reg;
        end
        out_valid_next = out_valid_reg && !m_ready;
        if (cw.give_out && !out_busy) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= isqrt_pkg::STEP_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
        if (accept) begin
            rad_reg <= s_radicand;
        end
        cur_reg  <= cur_next;
        prev_reg <= prev_next;
        if (cw.ld_next) begin
            next_reg <= sum[W:1];
        end
        if (cw.give_out && !out_busy) begin
            out_root_reg <= (cur_reg > isqrt_pkg::ROOT_MAX) ? '1
                                                           : cur_reg[isqrt_pkg::ROOT_W-1:0];
        end
    end

    assign s_ready = cw.take_in;
    assign m_valid = out_valid_reg;
    assign m_root  = out_root_reg;

    // The divider is never started with a zero estimate.
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cw.div_start |-> (cur_reg != '0))
        else $error("divider started with zero divisor");

    // No new radicand is taken while a division is running.
    a_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !div_busy)
        else $error("input ready while divider busy");

    // An accepted radicand moves the sequencer into its zero check.
    a_accept_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (pc_reg == isqrt_pkg::STEP_ZCHK))
        else $error("sequencer did not leave idle after accept");

    // Once the divider finishes, the average step follows.
    a_wait_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == isqrt_pkg::STEP_WAIT && !div_busy) |=> (pc_reg == isqrt_pkg::STEP_AVG))
        else $error("sequencer stuck after division");

    // A pending result is never overwritten before it is taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_root)))
        else $error("pending result overwritten");

endmodule
